/* hw/rtl/dmbc_pkg.sv */
package dmbc_pkg;

  localparam int unsigned CfgDataWidth = 12;
  localparam int unsigned CfgIdxWidth  = 3;

  typedef enum logic [CfgIdxWidth-1:0] {
    CfgEnterPitch  = 3'd0,
    CfgEnterCount  = 3'd1,
    CfgExitPitch   = 3'd2,
    CfgExitCount   = 3'd3,
    CfgLightPitch  = 3'd4,
    CfgMediumPitch = 3'd5,
    CfgRollLimit   = 3'd6,
    CfgStopDist    = 3'd7
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ActNone    = 2'd0,
    ActForward = 2'd1,
    ActReverse = 2'd2,
    ActStop    = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    EvtNone     = 2'd0,
    EvtRoll     = 2'd1,
    EvtObstacle = 2'd2,
    EvtDone     = 2'd3
  } event_e;

  localparam logic [7:0] SpeedNoBrake = 8'd60;
  localparam logic [7:0] SpeedLight   = 8'd80;
  localparam logic [7:0] SpeedMedium  = 8'd120;
  localparam logic [3:0] CountMax     = 4'd15;

  typedef struct packed {
    logic signed [10:0] enter_pitch;
    logic [3:0]         enter_count;
    logic signed [10:0] exit_pitch;
    logic [3:0]         exit_count;
    logic signed [10:0] light_pitch;
    logic signed [10:0] medium_pitch;
    logic [9:0]         roll_limit;
    logic [11:0]        stop_distance;
  } cfg_t;

  typedef struct packed {
    logic signed [11:0] pitch;
    logic signed [11:0] roll;
    logic [11:0]        distance;
  } sample_t;

  typedef struct packed {
    logic               descent_mode;
    action_e            action;
    logic [7:0]         speed;
    event_e             evt;
    logic signed [11:0] steepest_pitch;
  } result_t;

endpackage

/* hw/rtl/dmbc_cfg_regs.sv */
module dmbc_cfg_regs (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 wr_en_i,
  input  logic [dmbc_pkg::CfgIdxWidth-1:0]     wr_index_i,
  input  logic [dmbc_pkg::CfgDataWidth-1:0]    wr_data_i,
  output dmbc_pkg::cfg_t                       cfg_o
);
  import dmbc_pkg::*;

  cfg_t cfg_q;

  assign cfg_o = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.enter_pitch   <= -11'sd100;
      cfg_q.enter_count   <= 4'd3;
      cfg_q.exit_pitch    <= -11'sd30;
      cfg_q.exit_count    <= 4'd3;
      cfg_q.light_pitch   <= -11'sd120;
      cfg_q.medium_pitch  <= -11'sd150;
      cfg_q.roll_limit    <= 10'd200;
      cfg_q.stop_distance <= 12'd200;
    end else if (wr_en_i) begin
      unique case (cfg_idx_e'(wr_index_i))
        CfgEnterPitch:  cfg_q.enter_pitch   <= wr_data_i[10:0];
        CfgEnterCount:  cfg_q.enter_count   <= wr_data_i[3:0];
        CfgExitPitch:   cfg_q.exit_pitch    <= wr_data_i[10:0];
        CfgExitCount:   cfg_q.exit_count    <= wr_data_i[3:0];
        CfgLightPitch:  cfg_q.light_pitch   <= wr_data_i[10:0];
        CfgMediumPitch: cfg_q.medium_pitch  <= wr_data_i[10:0];
        CfgRollLimit:   cfg_q.roll_limit    <= wr_data_i[9:0];
        CfgStopDist:    cfg_q.stop_distance <= wr_data_i[11:0];
      endcase
    end
  end

  // counts stay within their 4 bit field whatever was written
  a_count_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i && (cfg_idx_e'(wr_index_i) == CfgEnterCount)
    |=> cfg_q.enter_count == $past(wr_data_i[3:0]))
    else $error("enter count not taken from write data");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !wr_en_i |=> $stable(cfg_q))
    else $error("configuration changed without a write");

  a_stop_dist: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_i && (cfg_idx_e'(wr_index_i) == CfgStopDist)
    |=> cfg_q.stop_distance == $past(wr_data_i))
    else $error("stop distance not taken from write data");

endmodule

/* hw/rtl/dmbc_core.sv */
module dmbc_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  dmbc_pkg::sample_t sample_i,
  input  dmbc_pkg::cfg_t    cfg_i,
  output dmbc_pkg::result_t result_o
);
  import dmbc_pkg::*;

  logic               mode_q, mode_d;
  logic [3:0]         entry_q, entry_d;
  logic [3:0]         exit_q, exit_d;
  logic signed [11:0] min_q, min_d;

  logic signed [11:0] pitch;
  logic signed [11:0] enter_ext, exit_ext, light_ext, medium_ext, base_min;
  logic [12:0]        roll_abs;
  logic [3:0]         entry_inc, exit_inc;
  logic               steep;

  always_comb begin
    pitch      = sample_i.pitch;
    enter_ext  = {cfg_i.enter_pitch[10], cfg_i.enter_pitch};
    exit_ext   = {cfg_i.exit_pitch[10], cfg_i.exit_pitch};
    light_ext  = {cfg_i.light_pitch[10], cfg_i.light_pitch};
    medium_ext = {cfg_i.medium_pitch[10], cfg_i.medium_pitch};
    roll_abs   = sample_i.roll[11] ? (13'd0 - {sample_i.roll[11], sample_i.roll})
                                   : {1'b0, sample_i.roll};
    entry_inc  = (entry_q != CountMax) ? entry_q + 4'd1 : entry_q;
    exit_inc   = (exit_q != CountMax) ? exit_q + 4'd1 : exit_q;
    steep      = pitch < enter_ext;
    base_min   = mode_q ? min_q : pitch;

    mode_d  = mode_q;
    entry_d = entry_q;
    exit_d  = exit_q;
    min_d   = min_q;
    result_o.action = ActNone;
    result_o.speed  = '0;
    result_o.evt    = EvtNone;

    if (steep) begin
      entry_d = entry_inc;
      if (entry_inc >= cfg_i.enter_count) begin
        mode_d = 1'b1;
        min_d  = (pitch < base_min) ? pitch : base_min;
        priority if (roll_abs > {3'b000, cfg_i.roll_limit}) begin
          result_o.action = ActStop;
          result_o.evt    = EvtRoll;
        end else if (sample_i.distance < cfg_i.stop_distance) begin
          result_o.action = ActStop;
          result_o.evt    = EvtObstacle;
        end else if (pitch < medium_ext) begin
          result_o.action = ActReverse;
          result_o.speed  = SpeedMedium;
        end else if (pitch < light_ext) begin
          result_o.action = ActReverse;
          result_o.speed  = SpeedLight;
        end else begin
          result_o.action = ActForward;
          result_o.speed  = SpeedNoBrake;
        end
      end
    end else begin
      entry_d = '0;
      if (mode_q && (pitch > exit_ext)) begin
        if (exit_inc >= cfg_i.exit_count) begin
          mode_d = 1'b0;
          exit_d = '0;
          min_d  = '0;
          result_o.action = ActStop;
          result_o.evt    = EvtDone;
        end else begin
          exit_d = exit_inc;
        end
      end else begin
        exit_d = '0;
      end
    end

    result_o.descent_mode   = mode_d;
    result_o.steepest_pitch = min_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= 1'b0;
      entry_q <= '0;
      exit_q  <= '0;
      min_q   <= '0;
    end else if (fire_i) begin
      mode_q  <= mode_d;
      entry_q <= entry_d;
      exit_q  <= exit_d;
      min_q   <= min_d;
    end
  end

  a_min_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mode_q |-> min_q == '0)
    else $error("steepest pitch kept outside descent");

  a_done_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire_i && result_o.evt == EvtDone |=> !mode_q && exit_q == '0)
    else $error("descent completion did not clear mode");

  a_exit_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !mode_q |-> exit_q == '0)
    else $error("exit counter running outside descent");

endmodule

/* hw/rtl/descent_mode_brake_controller.sv */
// channel   direction  handshake                 payload
// in        sink       in_valid_i / in_stall_o   pitch_i, roll_i, distance_i
// out       source     out_valid_o / out_stall_i descent_mode_o .. steepest_pitch_o
// cfg       sink       cfg_valid_i / cfg_ready_o cfg_index_i, cfg_data_i
//
// one transaction per cycle sustained while out does not stall; a sample passes
// the input register, then decision logic into the result register
// rst_ni clears control, mode state and loads the register defaults
// a stalled result holds in the output register while one more sample waits
// in the input register; in_stall_o rises only when both are full and out stalls
module descent_mode_brake_controller (
  input  logic               clk_i,
  input  logic               rst_ni,
  // sample input channel
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic signed [11:0] pitch_i,
  input  logic signed [11:0] roll_i,
  input  logic [11:0]        distance_i,
  // result channel
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic               descent_mode_o,
  output logic [1:0]         motor_action_o,
  output logic [7:0]         motor_speed_o,
  output logic [1:0]         event_code_o,
  output logic signed [11:0] steepest_pitch_o,
  // register write channel
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [2:0]         cfg_index_i,
  input  logic [11:0]        cfg_data_i
);
  import dmbc_pkg::*;

  // input register stage
  logic    in_valid_q, in_valid_d;
  sample_t sample_q;
  // result register stage
  logic    out_valid_q, out_valid_d;
  result_t result_q, result_c;

  cfg_t    cfg;
  logic    in_accept;
  logic    advance;

  // register writes are always taken
  assign cfg_ready_o = 1'b1;

  dmbc_cfg_regs u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (cfg_valid_i),
    .wr_index_i(cfg_index_i),
    .wr_data_i (cfg_data_i),
    .cfg_o     (cfg)
  );

  // the sample moves on when the result register is empty or being drained
  assign advance    = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  // mode state updates only when a sample actually moves to the result stage
  dmbc_core u_core (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .fire_i  (advance),
    .sample_i(sample_q),
    .cfg_i   (cfg),
    .result_o(result_c)
  );

  always_comb begin
    in_valid_d  = in_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
    out_valid_d = advance ? 1'b1 : (out_valid_q && out_stall_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers, no reset needed
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sample_q.pitch    <= pitch_i;
      sample_q.roll     <= roll_i;
      sample_q.distance <= distance_i;
    end
    if (advance) begin
      result_q <= result_c;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign descent_mode_o   = result_q.descent_mode;
  assign motor_action_o   = result_q.action;
  assign motor_speed_o    = result_q.speed;
  assign event_code_o     = result_q.evt;
  assign steepest_pitch_o = result_q.steepest_pitch;

  // drive commands only come out while descending
  a_cmd_in_descent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !result_q.descent_mode
    |-> (result_q.action == ActNone || result_q.action == ActStop))
    else $error("drive command outside descent");

  a_speed_action: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q
    |-> ((result_q.action == ActForward || result_q.action == ActReverse)
         == (result_q.speed != '0)))
    else $error("speed does not match action");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && out_stall_i |-> in_stall_o)
    else $error("input taken while both stages blocked");

  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_stall_i |=> out_valid_q && $stable(result_q))
    else $error("stalled result lost or changed");

endmodule
